FILE: hw/rtl/lrukv_pkg.sv
// Package for the LRU key-value cache: word types, controller states,
// command/status bundles and fixed constants. No dependencies.
package lrukv_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic              found;
        logic signed [31:0] read_value;
        logic              evicted;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
        logic respond;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

FILE: hw/rtl/lrukv_ctrl.sv
// Controller state machine of the LRU key-value cache.
// Depends on lrukv_pkg (state_t, dp_cmd_t, dp_sts_t).
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MATCH;
            end
            ST_MATCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESP;
            ST_RESP: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MATCH:  cmd.match  = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_RESP:   cmd.respond = sts.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lrukv_dp.sv
// Datapath of the LRU key-value cache: key cells, recency ranks, value
// memory, capacity register and output register. Depends on lrukv_pkg.
module lrukv_dp
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  req_t             s_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             m_ready,
    output logic             m_valid,
    output rsp_t             m_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    req_t                   req_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [31:0]            key_reg   [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_rank_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_any_reg;
    logic [IDX_W-1:0] lru_idx_reg;
    logic             full_reg;

    logic signed [31:0] value_mem [MAX_ENTRIES];
    logic signed [31:0] rdata_reg;

    logic m_valid_reg;
    logic m_valid_next;
    rsp_t m_data_reg;

    logic [MAX_ENTRIES-1:0] match;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       lru_idx;
    logic [IDX_W-1:0]       free_idx;
    logic                   free_any;
    logic [CNT_W-1:0]       eff_cap;

    logic             is_put;
    logic             do_evict;
    logic             do_insert;
    logic [IDX_W-1:0] new_idx;
    logic [IDX_W-1:0] mem_addr;
    logic             mem_we;

    // Request and capacity registers
    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Clamp capacity into 1..MAX_ENTRIES
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(cap_reg) > 32'(MAX_ENTRIES)) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // Parallel compare; hit and LRU slots are one-hot, so OR-encode them
    always_comb begin
        match    = '0;
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == $unsigned(req_reg.lookup_key));
            if (match[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (valid_reg[i] && (CNT_W'(rank_reg[i]) == count_reg - CNT_W'(1))) begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
        hit = |match;
    end

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            hit_rank_reg <= hit_rank;
            free_idx_reg <= free_idx;
            free_any_reg <= free_any;
            lru_idx_reg  <= lru_idx;
            full_reg     <= (count_reg >= eff_cap);
        end
    end

    // Update decisions
    always_comb begin
        is_put    = (req_reg.operation == OP_PUT);
        do_evict  = is_put && !hit_reg && full_reg;
        do_insert = is_put && !hit_reg && (do_evict || free_any_reg);
        if (do_evict && !(free_any_reg && (free_idx_reg < lru_idx_reg))) begin
            new_idx = lru_idx_reg;
        end else begin
            new_idx = free_idx_reg;
        end
        mem_addr = hit_reg ? hit_idx_reg : new_idx;
        mem_we   = is_put && (hit_reg || do_insert);
    end

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (cmd.update) begin
            if (hit_reg) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IDX_W'(i) == hit_idx_reg) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end else if (do_insert) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IDX_W'(i) == new_idx) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end else if (do_evict && (IDX_W'(i) == lru_idx_reg)) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                if (!do_evict) count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) rank_reg[i] <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && do_insert) key_reg[new_idx] <= $unsigned(req_reg.lookup_key);
    end

    // Value memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (mem_we) value_mem[mem_addr] <= req_reg.write_value;
            rdata_reg <= value_mem[mem_addr];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            m_data_reg.found   <= hit_reg;
            m_data_reg.evicted <= do_evict;
            if (is_put) begin
                m_data_reg.read_value <= '0;
            end else if (hit_reg) begin
                m_data_reg.read_value <= rdata_reg;
            end else begin
                m_data_reg.read_value <= MISS_VALUE;
            end
        end
    end

    always_comb begin
        if (cmd.respond) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// LRU key-value cache, top level: ties controller and datapath together.
// Path: an accepted word passes the match, update and respond steps before the result
//   is valid; the controller walks idle, match, update and respond for every word, so a
//   new word is taken only in idle; a full output register stalls the respond step.
// Reset: synchronous active-low aresetn clears all valid bits, ranks, count and
//   handshake state; capacity returns to 16. Keys and values are left as is.
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    // Command bundle from the controller, status back from the datapath
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Controller: sequence one word at a time through match, update, respond
    lrukv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    // Datapath: parallel key compare, rank update across all entries,
    // value memory and the output register that decouples the result side
    lrukv_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    // At most one datapath step runs per cycle
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.load, dp_cmd.match, dp_cmd.update, dp_cmd.respond}))
        else $error("more than one datapath command active");

    // An accepted word goes straight into the match step
    a_accept_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (dp_cmd.match && !s_ready))
        else $error("accepted word did not enter match");

    // A respond step always leaves a valid result behind
    a_respond_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.respond |=> m_valid)
        else $error("result lost after respond");
`endif

endmodule

FILE: dv/lru_cache_checker.sv
`timescale 1ns / 100ps
// Result checker for lru_key_value_cache: watches both channels and the capacity
// port, keeps its own copy of the cache and compares every result word.
// Depends on lrukv_pkg for the word types and codes.
module lru_cache_checker
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  req_t             s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  rsp_t             m_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    logic [31:0]      slot_key [MAX_ENTRIES];
    logic [31:0]      slot_val [MAX_ENTRIES];
    bit               slot_used[MAX_ENTRIES];
    int unsigned      slot_age [MAX_ENTRIES];
    int unsigned      used_count;
    logic [CAP_W-1:0] capacity;
    rsp_t             predicted_replies[$];
    int               errors;

    // Zero behaves as one; anything above the slot count saturates.
    function automatic int unsigned capacity_limit();
        int unsigned c;
        c = capacity;
        if (c == 0) c = 1;
        if (c > MAX_ENTRIES) c = MAX_ENTRIES;
        return c;
    endfunction

    // Make a slot most recent; slots that were more recent age by one.
    function automatic void touch_slot(int s);
        int unsigned r;
        r = slot_age[s];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_used[i] && i != s && slot_age[i] < r) slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic rsp_t predict_access(req_t w);
        rsp_t        r;
        int          hit;
        int          slot;
        int unsigned limit;
        hit = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit < 0 && slot_used[i] && slot_key[i] == w.lookup_key) hit = i;
        end
        r.found      = (hit >= 0);
        r.read_value = '0;
        r.evicted    = 1'b0;
        if (w.operation == OP_GET) begin
            if (hit >= 0) begin
                r.read_value = slot_val[hit];
                touch_slot(hit);
            end else begin
                r.read_value = MISS_VALUE;
            end
        end else if (hit >= 0) begin
            slot_val[hit] = w.write_value;
            touch_slot(hit);
        end else begin
            limit = capacity_limit();
            if (used_count >= limit && used_count > 0) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!r.evicted && slot_used[i] && slot_age[i] == used_count - 1) begin
                        slot_used[i] = 1'b0;
                        slot_age[i]  = 0;
                        used_count--;
                        r.evicted = 1'b1;
                    end
                end
            end
            slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot < 0 && !slot_used[i]) slot = i;
            end
            if (slot >= 0) begin
                for (int j = 0; j < MAX_ENTRIES; j++) begin
                    if (slot_used[j]) slot_age[j]++;
                end
                slot_key[slot]  = w.lookup_key;
                slot_val[slot]  = w.write_value;
                slot_used[slot] = 1'b1;
                slot_age[slot]  = 0;
                used_count++;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            used_count = 0;
            capacity   = CAP_RESET;
            predicted_replies.delete();
        end else begin
            // Compare before predicting: a word accepted at this edge cannot be answered yet.
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: result word with nothing expected: ",
                                  "found=%0b value=%0d evicted=%0b"},
                                 $realtime, m_data.found, m_data.read_value,
                                 m_data.evicted);
                end else begin
                    want = predicted_replies.pop_front();
                    if (m_data.found !== want.found || m_data.read_value !== want.read_value ||
                        m_data.evicted !== want.evicted) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result mismatch: expected found=%0b value=%0d ",
                                      "evicted=%0b, got found=%0b value=%0d evicted=%0b"},
                                     $realtime, want.found, want.read_value, want.evicted,
                                     m_data.found, m_data.read_value, m_data.evicted);
                    end
                end
            end
            if (s_valid && s_ready) predicted_replies.push_back(predict_access(s_data));
            if (cfg_we) capacity = cfg_wdata;
        end
        mismatches  <= errors;
        outstanding <= predicted_replies.size();
    end

endmodule

FILE: dv/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// Top of the lru_key_value_cache testbench: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on lrukv_pkg, the block
// and lru_cache_checker, which does all of the prediction and comparison.
module tb_lru_key_value_cache;
    import lrukv_pkg::*;

    localparam int MAX_ENTRIES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 155;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    req_t             s_data;
    logic             m_valid;
    logic             m_ready;
    rsp_t             m_data;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    int               mismatches;
    int               outstanding;
    int               idle_run;
    int               sink_stall;
    bit               sink_calm;
    bit               src_calm;
    logic [31:0]      key_pool[32];
    int               pool_size;

    // 8 ns period, first rising edge at 4 ns.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lru_key_value_cache #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    lru_cache_checker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // Gap or stall length: mostly a few cycles, now and then a long one.
    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: drop m_ready for random stretches unless in a calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            m_ready    <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0) sink_stall <= stall_len();
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    initial begin
        wait (idle_run >= WATCHDOG_LIMIT);
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, outstanding);
        $display("== FAIL ==");
        $finish;
    end

    // Present one request word after an optional gap and hold it until taken.
    // Valid only drops when there is a gap, so back-to-back words keep it high.
    task automatic issue(input logic op, input logic [31:0] key, input logic [31:0] val);
        req_t w;
        int   gap;
        w.operation   = op;
        w.lookup_key  = key;
        w.write_value = val;
        gap = (src_calm || $urandom_range(0, 3) != 0) ? 0 : stall_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every result to drain, then write the capacity.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Draw a fresh key pool from the clamped capacity up to 8 keys larger, so that hits,
    // overwrites and evictions all occur; sprinkle in the key extremes.
    task automatic refill_pool(input int unsigned cap);
        int unsigned lim;
        lim = (cap == 0) ? 1 : (cap > MAX_ENTRIES ? MAX_ENTRIES : cap);
        pool_size = lim + $urandom_range(0, 8);
        for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 11))
                0:       key_pool[i] = 32'h8000_0000;
                1:       key_pool[i] = 32'h7FFF_FFFF;
                2:       key_pool[i] = 32'h0000_0000;
                3:       key_pool[i] = 32'hFFFF_FFFF;
                default: key_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [CAP_W-1:0] caps[10];
        logic             op;
        logic [31:0]      key;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        sink_calm <= 1'b0;
        src_calm  = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at reset capacity: miss on an empty cache, key and
        // value extremes, a stored value that looks like the miss code,
        // overwrite of a present key, and a get whose write field is ignored.
        issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
        issue(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        issue(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_GET, 32'h8000_0000, 32'h0000_0000);
        issue(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        issue(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_GET, 32'h0000_0001, 32'h0000_0000);
        issue(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);

        // Lower capacity under the fill level: each new key evicts exactly one.
        set_capacity(5'd1);
        issue(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
        issue(OP_GET, 32'h5555_5555, 32'h0000_0000);
        issue(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        issue(OP_GET, 32'h8000_0000, 32'h0000_0000);

        // Capacity zero acts as one; an oversized capacity saturates.
        set_capacity(5'd0);
        issue(OP_PUT, 32'h0000_0001, 32'h0000_0001);
        issue(OP_PUT, 32'h0000_0002, 32'h0000_0002);
        issue(OP_GET, 32'h0000_0001, 32'h0000_0000);
        set_capacity(5'd31);
        issue(OP_PUT, 32'h0000_0003, 32'h0000_0003);
        issue(OP_GET, 32'h0000_0003, 32'h0000_0000);

        // Random phases over a spread of capacities, extremes included.
        caps[0] = 5'd16;
        caps[1] = 5'd1;
        caps[2] = 5'd0;
        caps[3] = 5'd31;
        caps[4] = 5'd4;
        caps[5] = 5'd16;
        caps[6] = 5'($urandom_range(2, 15));
        caps[7] = 5'd1;
        caps[8] = 5'($urandom_range(17, 30));
        caps[9] = 5'd8;
        for (int p = 0; p < 10; p++) begin
            set_capacity(caps[p]);
            refill_pool(caps[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Re-pick idling behavior in stretches so calm runs appear too.
                if (n % 40 == 0) begin
                    src_calm  = ($urandom_range(0, 3) == 0);
                    sink_calm <= ($urandom_range(0, 3) == 0);
                end
                op  = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
                key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                : $urandom;
                issue(op, key, pick_value());
            end
        end

        // Drain: wait for the last result, then a few more cycles for strays.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
